// ===== hdl/mie_pkg.sv =====
`timescale 1ns / 1ps
package mie_pkg;
   localparam int WIDTH_DEF = 16;

   localparam logic [1:0] CMD_POW    = 2'd0;
   localparam logic [1:0] CMD_FERMAT = 2'd1;
   localparam logic [1:0] CMD_EULER  = 2'd2;
   localparam logic [1:0] CMD_NONE   = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOT_COPR = 2'd1;
   localparam logic [1:0] ST_ZERO_MOD = 2'd2;
   localparam logic [1:0] ST_UNUSED   = 2'd3;
endpackage

// ===== hdl/mie_if.sv =====
`timescale 1ns / 1ps
interface mie_req_if #(parameter int W = mie_pkg::WIDTH_DEF);
   logic         valid;
   logic         ready;
   logic [1:0]   cmd;
   logic [W-1:0] base;
   logic [W-1:0] exponent;
   logic [W-1:0] modulus;
   modport source (output valid, cmd, base, exponent, modulus, input ready);
   modport sink   (input valid, cmd, base, exponent, modulus, output ready);
endinterface

interface mie_rsp_if #(parameter int W = mie_pkg::WIDTH_DEF);
   logic         valid;
   logic         ready;
   logic [W-1:0] result;
   logic [1:0]   status;
   modport source (output valid, result, status, input ready);
   modport sink   (input valid, result, status, output ready);
endinterface

// ===== hdl/modular_inverse_engine_core.sv =====
`timescale 1ns / 1ps
// Channel    Dir  Port      Word
// request    in   req_chan  cmd, base, exponent, modulus
// response   out  rsp_chan  result, status
//
// Flow: one word at a time. Power: one modular multiply per clear exponent bit,
// two per set bit (shared bit-serial modular multiplier), plus a division
// for the base reduction.
// Euler adds Euclid and trial division on one bit-serial divider.
// Reset: synchronous, clears the sequencer and the response valid.
// Stalls: a finished word waits in the response register; the next request
// is taken meanwhile, and only its completion waits for the register.
module modular_inverse_engine_core #(
   parameter int WIDTH = mie_pkg::WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   mie_req_if.sink    req_chan,
   mie_rsp_if.source  rsp_chan
);
   localparam int SQW = 2 * WIDTH + 2;

   typedef enum logic [13:0] {
      S_IDLE      = 14'b00000000000001,
      S_GCD       = 14'b00000000000010,
      S_GCD_W     = 14'b00000000000100,
      S_TOT_EVEN  = 14'b00000000001000,
      S_TOT_CHK   = 14'b00000000010000,
      S_TOT_DIVN  = 14'b00000000100000,
      S_TOT_PHI   = 14'b00000001000000,
      S_TOT_STRIP = 14'b00000010000000,
      S_TOT_LAST  = 14'b00000100000000,
      S_POW_RED   = 14'b00001000000000,
      S_POW_LOOP  = 14'b00010000000000,
      S_POW_MUL   = 14'b00100000000000,
      S_POW_SQ    = 14'b01000000000000,
      S_FIN       = 14'b10000000000000
   } state_type;

   state_type        state_ff, state_in;
   logic [WIDTH-1:0] base_ff, base_in, mod_ff, mod_in, exp_ff, exp_in;
   logic [WIDTH-1:0] b_ff, b_in, acc_ff, acc_in;      // power loop
   logic [WIDTH-1:0] x_ff, x_in, y_ff, y_in;          // Euclid
   logic [WIDTH-1:0] n_ff, n_in, phi_ff, phi_in, p_ff, p_in;
   logic [SQW-1:0]   sq_ff, sq_in;                    // p*p, kept incrementally
   logic [WIDTH-1:0] res_ff, res_in;
   logic [1:0]       st_ff, st_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [WIDTH-1:0] rsp_res_ff, rsp_res_in;
   logic [1:0]       rsp_st_ff, rsp_st_in;

   logic             div_start, div_done;
   logic [WIDTH-1:0] div_a, div_b, div_q, div_r;
   logic             mm_start, mm_done;
   logic [WIDTH-1:0] mm_a, mm_x, mm_p;
   logic             req_take, slot_free;

   mie_div #(.WIDTH(WIDTH)) u_div (
      .clock, .reset, .start(div_start), .dividend(div_a), .divisor(div_b),
      .done(div_done), .quot(div_q), .rem(div_r)
   );

   mie_mmul #(.WIDTH(WIDTH)) u_mmul (
      .clock, .reset, .start(mm_start), .a(mm_a), .x(mm_x), .m(mod_ff),
      .done(mm_done), .prod(mm_p)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_take       = req_chan.valid && (state_ff == S_IDLE);
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in = state_ff;
      base_in = base_ff; mod_in = mod_ff; exp_in = exp_ff;
      b_in = b_ff; acc_in = acc_ff; x_in = x_ff; y_in = y_ff;
      n_in = n_ff; phi_in = phi_ff; p_in = p_ff; sq_in = sq_ff;
      res_in = res_ff; st_in = st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_res_in = rsp_res_ff; rsp_st_in = rsp_st_ff;
      div_start = 1'b0; div_a = base_ff; div_b = mod_ff;
      mm_start = 1'b0; mm_a = b_ff; mm_x = b_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               base_in = req_chan.base;
               mod_in  = req_chan.modulus;
               res_in  = '0;
               st_in   = mie_pkg::ST_OK;
               if (req_chan.cmd == mie_pkg::CMD_NONE) begin
                  state_in = S_FIN;
               end else if (req_chan.modulus == '0) begin
                  st_in    = mie_pkg::ST_ZERO_MOD;
                  state_in = S_FIN;
               end else if (req_chan.cmd == mie_pkg::CMD_POW) begin
                  exp_in    = req_chan.exponent;
                  div_start = 1'b1;
                  div_a     = req_chan.base;
                  div_b     = req_chan.modulus;
                  state_in  = S_POW_RED;
               end else if (req_chan.cmd == mie_pkg::CMD_FERMAT) begin
                  if (req_chan.modulus < WIDTH'(2)) begin
                     res_in   = WIDTH'(1);
                     state_in = S_FIN;
                  end else begin
                     exp_in    = req_chan.modulus - WIDTH'(2);
                     div_start = 1'b1;
                     div_a     = req_chan.base;
                     div_b     = req_chan.modulus;
                     state_in  = S_POW_RED;
                  end
               end else begin
                  x_in     = req_chan.base;
                  y_in     = req_chan.modulus;
                  state_in = S_GCD;
               end
            end
         end
         S_GCD: begin
            if (y_ff == '0) begin
               if (x_ff != WIDTH'(1)) begin
                  st_in    = mie_pkg::ST_NOT_COPR;
                  state_in = S_FIN;
               end else begin
                  n_in     = mod_ff;
                  phi_in   = mod_ff[0] ? mod_ff : (mod_ff - (mod_ff >> 1));
                  state_in = S_TOT_EVEN;
               end
            end else begin
               div_start = 1'b1;
               div_a     = x_ff;
               div_b     = y_ff;
               state_in  = S_GCD_W;
            end
         end
         S_GCD_W: begin
            if (div_done) begin
               x_in     = y_ff;
               y_in     = div_r;
               state_in = S_GCD;
            end
         end
         S_TOT_EVEN: begin
            // strip factors of two, one per cycle
            if (!n_ff[0]) begin
               n_in = n_ff >> 1;
            end else begin
               p_in     = WIDTH'(3);
               sq_in    = SQW'(9);
               state_in = S_TOT_CHK;
            end
         end
         S_TOT_CHK: begin
            if (sq_ff <= {{(SQW-WIDTH){1'b0}}, n_ff}) begin
               div_start = 1'b1;
               div_a     = n_ff;
               div_b     = p_ff;
               state_in  = S_TOT_DIVN;
            end else if (n_ff > WIDTH'(1)) begin
               div_start = 1'b1;
               div_a     = phi_ff;
               div_b     = n_ff;
               state_in  = S_TOT_LAST;
            end else begin
               exp_in    = phi_ff - WIDTH'(1);
               div_start = 1'b1;
               state_in  = S_POW_RED;
            end
         end
         S_TOT_DIVN: begin
            if (div_done) begin
               if (div_r == '0) begin
                  n_in      = div_q;
                  div_start = 1'b1;
                  div_a     = phi_ff;
                  div_b     = p_ff;
                  state_in  = S_TOT_PHI;
               end else begin
                  p_in     = p_ff + WIDTH'(2);
                  sq_in    = sq_ff + {{(SQW-WIDTH-2){1'b0}}, p_ff, 2'b00} + SQW'(4);
                  state_in = S_TOT_CHK;
               end
            end
         end
         S_TOT_PHI: begin
            if (div_done) begin
               phi_in    = phi_ff - div_q;
               div_start = 1'b1;
               div_a     = n_ff;
               div_b     = p_ff;
               state_in  = S_TOT_STRIP;
            end
         end
         S_TOT_STRIP: begin
            if (div_done) begin
               if (div_r == '0) begin
                  n_in      = div_q;
                  div_start = 1'b1;
                  div_a     = div_q;
                  div_b     = p_ff;
               end else begin
                  p_in     = p_ff + WIDTH'(2);
                  sq_in    = sq_ff + {{(SQW-WIDTH-2){1'b0}}, p_ff, 2'b00} + SQW'(4);
                  state_in = S_TOT_CHK;
               end
            end
         end
         S_TOT_LAST: begin
            if (div_done) begin
               exp_in    = phi_ff - div_q - WIDTH'(1);
               div_start = 1'b1;
               state_in  = S_POW_RED;
            end
         end
         S_POW_RED: begin
            if (div_done) begin
               b_in     = div_r;
               acc_in   = WIDTH'(1);
               state_in = S_POW_LOOP;
            end
         end
         S_POW_LOOP: begin
            if (exp_ff == '0) begin
               res_in   = acc_ff;
               state_in = S_FIN;
            end else if (exp_ff[0]) begin
               mm_start = 1'b1;
               mm_x     = acc_ff;
               state_in = S_POW_MUL;
            end else begin
               mm_start = 1'b1;
               state_in = S_POW_SQ;
            end
         end
         S_POW_MUL: begin
            if (mm_done) begin
               acc_in   = mm_p;
               mm_start = 1'b1;
               state_in = S_POW_SQ;
            end
         end
         S_POW_SQ: begin
            if (mm_done) begin
               b_in     = mm_p;
               exp_in   = exp_ff >> 1;
               state_in = S_POW_LOOP;
            end
         end
         S_FIN: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_res_in   = res_ff;
               rsp_st_in    = st_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff <= base_in; mod_ff <= mod_in; exp_ff <= exp_in;
      b_ff <= b_in; acc_ff <= acc_in; x_ff <= x_in; y_ff <= y_in;
      n_ff <= n_in; phi_ff <= phi_in; p_ff <= p_in; sq_ff <= sq_in;
      res_ff <= res_in; st_ff <= st_in;
      rsp_res_ff <= rsp_res_in; rsp_st_ff <= rsp_st_in;
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.result = rsp_res_ff;
   assign rsp_chan.status = rsp_st_ff;

   // an error word always carries a zero residue
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_st_ff != mie_pkg::ST_OK) |-> rsp_res_ff == '0)
      else $error("error word with non-zero result");

   a_st_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_st_ff != mie_pkg::ST_UNUSED)
      else $error("unused status code");

   a_mm_done: assert property (@(posedge clock) disable iff (reset)
      mm_done |-> (state_ff == S_POW_MUL) || (state_ff == S_POW_SQ))
      else $error("multiplier finished outside the power loop");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_GCD_W) || (state_ff == S_TOT_DIVN) ||
                   (state_ff == S_TOT_PHI) || (state_ff == S_TOT_STRIP) ||
                   (state_ff == S_TOT_LAST) || (state_ff == S_POW_RED))
      else $error("divider finished with nobody waiting");

   a_word_lost: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |=> rsp_valid_ff)
      else $error("pending word dropped");
endmodule

// ===== hdl/mie_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle. Divisor must be non-zero.
module mie_div #(parameter int WIDTH = mie_pkg::WIDTH_DEF) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quot,
   output logic [WIDTH-1:0] rem
);
   localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   logic             busy_ff, busy_in, done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [WIDTH-1:0] rem_ff, rem_in, q_ff, q_in, d_ff, d_in;
   logic [WIDTH:0]   sh, diff;

   always_comb begin
      sh      = {rem_ff, q_ff[WIDTH-1]};
      diff    = sh - {1'b0, d_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      d_in    = d_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(WIDTH - 1);
         rem_in  = '0;
         q_in    = dividend;
         d_in    = divisor;
      end else if (busy_ff) begin
         if (sh >= {1'b0, d_ff}) begin
            rem_in = diff[WIDTH-1:0];
            q_in   = {q_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = sh[WIDTH-1:0];
            q_in   = {q_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      d_ff   <= d_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
   assign rem  = rem_ff;
endmodule

// ===== hdl/mie_mmul.sv =====
`timescale 1ns / 1ps
// Interleaved modular multiply, multiplier scanned MSB first. Needs a < m.
module mie_mmul #(parameter int WIDTH = mie_pkg::WIDTH_DEF) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] x,
   input  logic [WIDTH-1:0] m,
   output logic             done,
   output logic [WIDTH-1:0] prod
);
   localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   logic             busy_ff, busy_in, done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [WIDTH-1:0] r_ff, r_in, a_ff, a_in, x_ff, x_in, m_ff, m_in;
   logic [WIDTH+1:0] t, m1, m2;

   always_comb begin
      m1 = {2'b00, m_ff};
      m2 = {1'b0, m_ff, 1'b0};
      t  = {1'b0, r_ff, 1'b0} + (x_ff[WIDTH-1] ? {2'b00, a_ff} : '0);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      r_in    = r_ff;
      a_in    = a_ff;
      x_in    = x_ff;
      m_in    = m_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(WIDTH - 1);
         r_in    = '0;
         a_in    = a;
         x_in    = x;
         m_in    = m;
      end else if (busy_ff) begin
         if (t >= m2)      r_in = WIDTH'(t - m2);
         else if (t >= m1) r_in = WIDTH'(t - m1);
         else              r_in = t[WIDTH-1:0];
         x_in   = {x_ff[WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      r_ff   <= r_in;
      a_ff   <= a_in;
      x_ff   <= x_in;
      m_ff   <= m_in;
   end

   assign done = done_ff;
   assign prod = r_ff;
endmodule

// ===== tb/sv/modular_inverse_engine_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the modular inverse engine: directed corner words, then random
// words, with random gaps on both sides and one long response stall.
module modular_inverse_engine_core_tb;

   localparam int W = mie_pkg::WIDTH_DEF;
   localparam longint CYCLE_LIMIT = 3_000_000;

   typedef struct packed {
      logic [1:0]   cmd;
      logic [W-1:0] base;
      logic [W-1:0] exponent;
      logic [W-1:0] modulus;
   } op_word_type;

   typedef struct packed {
      logic [W-1:0] result;
      logic [1:0]   status;
   } res_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mie_req_if #(.W(W)) req_chan ();
   mie_rsp_if #(.W(W)) rsp_chan ();

   modular_inverse_engine_core #(.WIDTH(W)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #5 clock = ~clock;

   op_word_type  pending_ops[$];
   res_word_type expected_residues[$];
   int           mismatch_count = 0;
   longint       cycle_count = 0;
   bit           stimulus_done = 1'b0;

   // ---------------------------------------------------------------
   // Arithmetic predictor, all at 64 bits so products never overflow
   // ---------------------------------------------------------------
   function automatic longint unsigned mod_power(longint unsigned b,
                                                 longint unsigned e,
                                                 longint unsigned m);
      longint unsigned acc;
      acc = 1;
      b = b % m;
      while (e > 0) begin
         if (e[0]) acc = (acc * b) % m;
         e = e >> 1;
         b = (b * b) % m;
      end
      return acc;
   endfunction

   function automatic longint unsigned euclid_gcd(longint unsigned x,
                                                  longint unsigned y);
      longint unsigned t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic longint unsigned euler_phi(longint unsigned n);
      longint unsigned phi;
      longint unsigned p;
      phi = n;
      if (n[0] == 1'b0 && n != 0) begin
         phi -= phi / 2;
         while (n[0] == 1'b0) n = n >> 1;
      end
      for (p = 3; p * p <= n; p += 2) begin
         if (n % p == 0) begin
            phi -= phi / p;
            while (n % p == 0) n = n / p;
         end
      end
      if (n > 1) phi -= phi / n;
      return phi;
   endfunction

   function automatic res_word_type predict_residue(op_word_type op);
      res_word_type r;
      longint unsigned b, e, m;
      b = op.base;
      e = op.exponent;
      m = op.modulus;
      r.result = '0;
      r.status = mie_pkg::ST_OK;
      if (op.cmd == mie_pkg::CMD_NONE) begin
         r.status = mie_pkg::ST_OK;
      end else if (m == 0) begin
         r.status = mie_pkg::ST_ZERO_MOD;
      end else if (op.cmd == mie_pkg::CMD_POW) begin
         r.result = W'(mod_power(b, e, m));
      end else if (op.cmd == mie_pkg::CMD_FERMAT) begin
         r.result = (m < 2) ? W'(1) : W'(mod_power(b, m - 2, m));
      end else begin
         if (euclid_gcd(b, m) != 1) r.status = mie_pkg::ST_NOT_COPR;
         else r.result = W'(mod_power(b, euler_phi(m) - 1, m));
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   task automatic queue_op(input logic [1:0] c, input logic [W-1:0] b,
                           input logic [W-1:0] e, input logic [W-1:0] m);
      op_word_type op;
      op.cmd = c;
      op.base = b;
      op.exponent = e;
      op.modulus = m;
      pending_ops = {pending_ops, op};
   endtask

   // ---------------------------------------------------------------
   // Driver: one word per handshake, random gap before each word
   // ---------------------------------------------------------------
   int req_gap = 0;
   bit req_fired = 1'b0;   // handshake seen at the last rising edge

   initial begin
      req_chan.valid = 1'b0;
      req_chan.cmd = '0;
      req_chan.base = '0;
      req_chan.exponent = '0;
      req_chan.modulus = '0;
   end

   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (req_chan.valid && !req_fired) begin
         // holding the current word
      end else if (req_gap > 0) begin
         req_chan.valid <= 1'b0;
         req_gap <= req_gap - 1;
      end else if (pending_ops.size() > 0) begin
         op_word_type op;
         op = pending_ops.pop_front();
         req_chan.valid <= 1'b1;
         req_chan.cmd <= op.cmd;
         req_chan.base <= op.base;
         req_chan.exponent <= op.exponent;
         req_chan.modulus <= op.modulus;
         // bursts with no gap now and then
         req_gap <= (pending_ops.size() % 40 < 12) ? 0 : $urandom_range(0, 18);
      end else begin
         req_chan.valid <= 1'b0;
      end
   end

   // prediction at acceptance
   always @(posedge clock) begin
      req_fired <= !reset && req_chan.valid && req_chan.ready;
      if (!reset && req_chan.valid && req_chan.ready) begin
         op_word_type op;
         op.cmd = req_chan.cmd;
         op.base = req_chan.base;
         op.exponent = req_chan.exponent;
         op.modulus = req_chan.modulus;
         expected_residues = {expected_residues, predict_residue(op)};
      end
   end

   // ---------------------------------------------------------------
   // Receiver: random stalls, plus one long hold-off to back up the core
   // ---------------------------------------------------------------
   int  rsp_gap = 0;
   int  hold_cycles = 0;
   int  words_seen = 0;
   bit  hold_done = 1'b0;

   initial rsp_chan.ready = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (!hold_done && words_seen == 30) begin
         // long stall: the core finishes one word and takes the next request
         rsp_chan.ready <= 1'b0;
         hold_cycles <= hold_cycles + 1;
         if (hold_cycles >= 20000) hold_done <= 1'b1;
      end else if (rsp_gap > 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_gap <= rsp_gap - 1;
      end else begin
         rsp_chan.ready <= 1'b1;
         if (rsp_chan.ready && rsp_chan.valid)
            rsp_gap <= (words_seen % 40 < 12) ? 0 : $urandom_range(0, 18);
      end
   end

   // Monitor: compare each accepted word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         res_word_type want;
         words_seen <= words_seen + 1;
         if (expected_residues.size() == 0) begin
            report_mismatch($sformatf("unexpected word result=%0d status=%0d",
                                      rsp_chan.result, rsp_chan.status));
         end else begin
            want = expected_residues.pop_front();
            if (rsp_chan.result !== want.result)
               report_mismatch($sformatf("result %0d, want %0d",
                                         rsp_chan.result, want.result));
            if (rsp_chan.status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d",
                                         rsp_chan.status, want.status));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------
   initial begin
      int n;
      logic [1:0] c;
      logic [W-1:0] b, e, m;

      // directed corners
      queue_op(mie_pkg::CMD_POW, 16'd3, 16'd5, 16'd0);         // zero modulus
      queue_op(mie_pkg::CMD_FERMAT, 16'd3, 16'd5, 16'd0);
      queue_op(mie_pkg::CMD_EULER, 16'd3, 16'd5, 16'd0);
      queue_op(mie_pkg::CMD_POW, 16'd7, 16'd0, 16'd1);   // zero exponent, modulus 1
      queue_op(mie_pkg::CMD_POW, 16'd7, 16'd0, 16'd13);
      queue_op(mie_pkg::CMD_POW, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      queue_op(mie_pkg::CMD_POW, 16'hFFFF, 16'hFFFF, 16'hFFF1);
      queue_op(mie_pkg::CMD_POW, 16'd0, 16'd0, 16'd1);
      queue_op(mie_pkg::CMD_FERMAT, 16'd5, 16'd0, 16'd1);      // Fermat, modulus 1
      queue_op(mie_pkg::CMD_FERMAT, 16'd5, 16'd0, 16'd2);      // Fermat, modulus 2
      queue_op(mie_pkg::CMD_FERMAT, 16'd3, 16'd0, 16'd65521);  // prime modulus
      queue_op(mie_pkg::CMD_FERMAT, 16'd4, 16'd0, 16'd15);     // composite, unchecked
      queue_op(mie_pkg::CMD_FERMAT, 16'd26, 16'd0, 16'd13);    // base multiple of modulus
      queue_op(mie_pkg::CMD_EULER, 16'd6, 16'd0, 16'd9);       // not coprime
      queue_op(mie_pkg::CMD_EULER, 16'd0, 16'd0, 16'd7);       // zero base
      queue_op(mie_pkg::CMD_EULER, 16'd9, 16'd0, 16'd1);       // Euler, modulus 1
      queue_op(mie_pkg::CMD_EULER, 16'd7, 16'd0, 16'd65535);
      queue_op(mie_pkg::CMD_EULER, 16'hFFFF, 16'hFFFF, 16'd65521);
      queue_op(mie_pkg::CMD_EULER, 16'd3, 16'd0, 16'd32768);
      queue_op(mie_pkg::CMD_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF); // unused code
      queue_op(mie_pkg::CMD_NONE, 16'd0, 16'd0, 16'd0);

      for (n = 0; n < 100; n++) begin
         if ($urandom_range(0, 15) == 0) c = mie_pkg::CMD_NONE;
         else c = 2'($urandom_range(0, 2));
         b = W'($urandom);
         e = W'($urandom);
         case ($urandom_range(0, 9))
            0: m = W'($urandom_range(0, 3));
            1: m = W'($urandom_range(65500, 65535));
            default: m = W'($urandom);
         endcase
         queue_op(c, b, e, m);
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      wait (pending_ops.size() == 0 && !req_chan.valid);
      wait (expected_residues.size() == 0);
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && expected_residues.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule
